// ===== rtl/chacha20_stream_cipher_macros.svh =====
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher assertion macros
// Concurrent assertion helpers, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef CHACHA20_STREAM_CIPHER_MACROS_SVH
`define CHACHA20_STREAM_CIPHER_MACROS_SVH
`ifndef SYNTHESIS
`define CC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define CC_ASSERT(label, clk, rst_n, prop, msg)
`define CC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/cc20_pkg.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 package
// Shared types, register indexes and helpers.
// ----------------------------------------------------------------------------
package cc20_pkg;
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegKey0   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKey1   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKey2   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKey3   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegNonceL = 3'd4;
  localparam logic [CfgIdxW-1:0] RegNonceH = 3'd5;
  localparam logic [CfgIdxW-1:0] RegStart  = 3'd6;

  // item queued between front and back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  // block request from byte core to block core
  typedef struct packed {
    logic        req;
    logic [31:0] counter;
  } blk_req_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction
endpackage

// ===== rtl/chacha20_stream_cipher.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher
// Byte-wide keystream XOR, RFC 8439 block function, 32-bit block counter.
// ----------------------------------------------------------------------------
// channel   dir  handshake             payload
// s_axis    in   s_axis_tvalid/tready  tdata=data_byte, tlast=last
// m_axis    out  m_axis_tvalid/tready  tdata=out_byte, tlast=out_last
// cfg       in   cfg_valid/cfg_ready   cfg_index_i, cfg_data_i
// One byte per cycle from the keystream buffer while the output is not stalled
// and no block is pending; a fresh 64-byte block takes a load, 80 quarter-round
// steps of the shared round unit, an add and a hand-back to the byte core.
// Reset leaves the buffer empty, so the first byte waits for a block.
// A two-entry input queue lets input run while the output is stalled.
`include "chacha20_stream_cipher_macros.svh"
module chacha20_stream_cipher import cc20_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata,   // [7:0] out_byte
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]  cfg_data_i
);
  logic [255:0] key_q;
  logic [95:0]  nonce_q;
  logic [31:0]  start_q;
  logic         cfg_we, restart;
  item_t        in_item, q_item, o_item;
  logic         q_valid, q_ready, done;
  blk_req_t     req;
  logic [511:0] blk;

  assign cfg_ready_o = 1'b1;
  assign cfg_we  = cfg_valid_i;
  assign restart = cfg_we && cfg_index_i == RegStart;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      nonce_q <= '0;
      start_q <= 32'd1;
    end else if (cfg_we) begin
      case (cfg_index_i)
        RegKey0:   key_q[63:0]    <= cfg_data_i;
        RegKey1:   key_q[127:64]  <= cfg_data_i;
        RegKey2:   key_q[191:128] <= cfg_data_i;
        RegKey3:   key_q[255:192] <= cfg_data_i;
        RegNonceL: nonce_q[63:0]  <= cfg_data_i;
        RegNonceH: nonce_q[95:64] <= cfg_data_i[31:0];
        RegStart:  start_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign in_item.data = s_axis_tdata;
  assign in_item.last = s_axis_tlast;

  cc20_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_item_i(in_item),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  cc20_block u_block (
    .clk_i, .rst_ni, .req_i(req), .key_i(key_q), .nonce_i(nonce_q),
    .done_o(done), .block_o(blk)
  );

  // a start counter write takes the new value; a last byte reloads the stored one
  cc20_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .restart_i(restart), .start_i(restart ? cfg_data_i[31:0] : start_q),
    .req_o(req), .done_i(done), .block_i(blk),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_item_o(o_item)
  );

  assign m_axis_tdata = o_item.data;
  assign m_axis_tlast = o_item.last;

  `CC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled output changed")
  `CC_ASSERT(a_no_take_on_req, clk_i, rst_ni, !(req.req && q_ready), "byte taken while block requested")
endmodule

// ===== rtl/cc20_front.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 front end
// Two-entry queue that takes input items and hands them to the back end.
// ----------------------------------------------------------------------------
module cc20_front import cc20_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  q_valid_o,
  input  logic  q_ready_i,
  output item_t q_item_o
);
  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_item_i;
  end
endmodule

// ===== rtl/cc20_block.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 block core
// One quarter-round per cycle on a 16-word state; 80 steps, then feed-forward.
// ----------------------------------------------------------------------------
module cc20_block import cc20_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  blk_req_t      req_i,
  input  logic [255:0]  key_i,
  input  logic [95:0]   nonce_i,
  output logic          done_o,
  output logic [511:0]  block_o
);
  typedef enum logic [1:0] {StIdle, StRound, StAdd} state_e;
  state_e        state_q;
  logic [6:0]    step_q;
  logic [31:0]   w_q [16];
  logic [31:0]   init_q [16];
  logic [511:0]  blk_q;
  logic          done_q;

  logic [3:0]  ia, ib, ic, id;
  logic [31:0] a0, b0, c0, d0, a1, b1, c1, d1, a2, b2, c2, d2;
  logic [1:0]  col;

  assign col = step_q[1:0];
  always_comb begin
    ia = {2'b00, col};
    if (!step_q[2]) begin
      ib = {2'b01, col};
      ic = {2'b10, col};
      id = {2'b11, col};
    end else begin
      ib = {2'b01, col + 2'd1};
      ic = {2'b10, col + 2'd2};
      id = {2'b11, col + 2'd3};
    end
    a0 = w_q[ia] + w_q[ib];
    d0 = rotl(w_q[id] ^ a0, 16);
    c0 = w_q[ic] + d0;
    b0 = rotl(w_q[ib] ^ c0, 12);
    a1 = a0 + b0;
    d1 = rotl(d0 ^ a1, 8);
    c1 = c0 + d1;
    b1 = rotl(b0 ^ c1, 7);
    a2 = a1; b2 = b1; c2 = c1; d2 = d1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        StIdle: if (req_i.req) begin
          state_q <= StRound;
          step_q <= '0;
        end
        StRound: begin
          if (step_q == 7'd79) state_q <= StAdd;
          step_q <= step_q + 7'd1;
        end
        StAdd: begin
          state_q <= StIdle;
          done_q <= 1'b1;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && req_i.req) begin
      w_q[0] <= 32'h61707865; init_q[0] <= 32'h61707865;
      w_q[1] <= 32'h3320646e; init_q[1] <= 32'h3320646e;
      w_q[2] <= 32'h79622d32; init_q[2] <= 32'h79622d32;
      w_q[3] <= 32'h6b206574; init_q[3] <= 32'h6b206574;
      for (int i = 0; i < 8; i++) begin
        w_q[4+i] <= key_i[32*i +: 32];
        init_q[4+i] <= key_i[32*i +: 32];
      end
      w_q[12] <= req_i.counter; init_q[12] <= req_i.counter;
      for (int i = 0; i < 3; i++) begin
        w_q[13+i] <= nonce_i[32*i +: 32];
        init_q[13+i] <= nonce_i[32*i +: 32];
      end
    end else if (state_q == StRound) begin
      w_q[ia] <= a2; w_q[ib] <= b2; w_q[ic] <= c2; w_q[id] <= d2;
    end else if (state_q == StAdd) begin
      for (int i = 0; i < 16; i++) blk_q[32*i +: 32] <= w_q[i] + init_q[i];
    end
  end

  assign done_o  = done_q;
  assign block_o = blk_q;
endmodule

// ===== rtl/cc20_back.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 back end
// Byte position and counter tracking, block requests, XOR and output register.
// ----------------------------------------------------------------------------
module cc20_back import cc20_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  output logic         q_ready_o,
  input  item_t        q_item_i,
  input  logic         restart_i,
  input  logic [31:0]  start_i,
  output blk_req_t     req_o,
  input  logic         done_i,
  input  logic [511:0] block_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output item_t        out_item_o
);
  typedef enum logic [1:0] {StRun, StWait} state_e;
  state_e      state_q;
  logic [6:0]  pos_q;
  logic [31:0] ctr_q;
  logic        ov_q;
  item_t       oi_q;
  logic        can_out, take, need;

  assign can_out   = !ov_q || out_ready_i;
  assign need      = pos_q[6];
  assign take      = state_q == StRun && q_valid_i && !need && can_out;
  assign q_ready_o = take;
  assign req_o.req = state_q == StRun && q_valid_i && need;
  assign req_o.counter = ctr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StRun;
      pos_q <= 7'd64;
      ctr_q <= 32'd1;
      ov_q <= 1'b0;
    end else begin
      if (out_ready_i) ov_q <= 1'b0;
      case (state_q)
        StRun: begin
          if (restart_i) begin
            pos_q <= 7'd64;
            ctr_q <= start_i;
          end else if (req_o.req) begin
            state_q <= StWait;
          end else if (take) begin
            ov_q <= 1'b1;
            if (q_item_i.last) begin
              pos_q <= 7'd64;
              ctr_q <= start_i;
            end else begin
              pos_q <= pos_q + 7'd1;
            end
          end
        end
        StWait: if (done_i) begin
          state_q <= StRun;
          pos_q <= 7'd0;
          ctr_q <= ctr_q + 32'd1;
        end
        default: state_q <= StRun;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      oi_q.data <= q_item_i.data ^ block_i[{pos_q[5:0], 3'b000} +: 8];
      oi_q.last <= q_item_i.last;
    end
  end

  assign out_valid_o = ov_q;
  assign out_item_o  = oi_q;
endmodule
